[rtl/c3zpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3zpc_pkg - shared types and constants for the 3x3 convolution block
// Item layouts, register indexes, reset values and the queue entry that
// carries a filled window from the line-buffer front to the filter back.
// ----------------------------------------------------------------------------
package c3zpc_pkg;

  // Sizing defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 1024;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Fixed field widths
  localparam int SIZE_W     = 11;
  localparam int KROW_W     = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int SAMPLE_W   = 8;
  localparam int PIX_W      = 3 * SAMPLE_W;
  localparam int PROD_W     = 12;
  localparam int SUM_W      = 16;
  localparam int TAPS       = 9;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_COLOR_MODE    = 3'd2,
    REG_KERNEL_TOP    = 3'd3,
    REG_KERNEL_MIDDLE = 3'd4,
    REG_KERNEL_BOTTOM = 3'd5
  } cfg_reg_t;

  // Reset values: 256 x 256 grayscale, sharpening mask in Q4.4
  localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH   = 11'd256;
  localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT  = 11'd256;
  localparam logic              RST_COLOR_MODE    = 1'b0;
  localparam logic [KROW_W-1:0] RST_KERNEL_TOP    = 24'h00F000;
  localparam logic [KROW_W-1:0] RST_KERNEL_MIDDLE = 24'hF050F0;
  localparam logic [KROW_W-1:0] RST_KERNEL_BOTTOM = 24'h00F000;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [2:0][2:0] win_t;   // [row][column], row 0 above, column 0 left

  typedef struct packed {
    logic                operation;
    logic [SAMPLE_W-1:0] sample0;
    logic [SAMPLE_W-1:0] sample1;
    logic [SAMPLE_W-1:0] sample2;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] out0;
    logic [SAMPLE_W-1:0] out1;
    logic [SAMPLE_W-1:0] out2;
    logic                last_pixel;
  } out_item_t;

  // Frame geometry plus the position clear raised by a geometry write
  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic              color;
    logic              clear;
  } geom_t;

  typedef struct packed {
    logic [KROW_W-1:0] top;
    logic [KROW_W-1:0] middle;
    logic [KROW_W-1:0] bottom;
  } kernel_t;

  // One emitting item: window, tap enables (row * 3 + column), mode, frame end
  typedef struct packed {
    win_t             win;
    logic [TAPS-1:0]  tap_en;
    logic             color;
    logic             last;
  } q_entry_t;

endpackage
`default_nettype wire

[rtl/conv3x3_zero_pad_clamp.sv]
`timescale 1ns / 1ps
`default_nettype none
// Path: the item that completes a pixel's window arrives width+1 items after
//   it and passes the second stage, queue, product stage and output register.
// Throughput: one item per clock, set by one read and one write of each line
//   store per item; the queue absorbs up to QUEUE_DEPTH results under stall.
// Reset: synchronous, active low; clears position, pipeline and queue, loads
//   256 x 256 grayscale and the sharpening kernel; line stores are not swept.
// ----------------------------------------------------------------------------
// conv3x3_zero_pad_clamp - streaming 3x3 convolution, zero border, clamped
// Raster pixel stream in, filtered pixel stream out, gray or RGB, with a
// programmable signed Q4.4 kernel and frame size.
// ----------------------------------------------------------------------------
module conv3x3_zero_pad_clamp
  import c3zpc_pkg::*;
#(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data
);

  logic [SIZE_W-1:0] width_r, height_r;
  logic              color_r;
  logic [KROW_W-1:0] ktop_r, kmid_r, kbot_r;

  geom_t    geom;
  kernel_t  kernel;
  logic     q_push, q_pop, q_full, q_empty;
  q_entry_t q_in, q_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
      color_r  <= RST_COLOR_MODE;
      ktop_r   <= RST_KERNEL_TOP;
      kmid_r   <= RST_KERNEL_MIDDLE;
      kbot_r   <= RST_KERNEL_BOTTOM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   width_r  <= cfg_wdata[SIZE_W-1:0];
        REG_IMAGE_HEIGHT:  height_r <= cfg_wdata[SIZE_W-1:0];
        REG_COLOR_MODE:    color_r  <= cfg_wdata[0];
        REG_KERNEL_TOP:    ktop_r   <= cfg_wdata[KROW_W-1:0];
        REG_KERNEL_MIDDLE: kmid_r   <= cfg_wdata[KROW_W-1:0];
        REG_KERNEL_BOTTOM: kbot_r   <= cfg_wdata[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  // A geometry write restarts the frame
  always_comb begin
    geom.width  = width_r;
    geom.height = height_r;
    geom.color  = color_r;
    geom.clear  = cfg_we && (cfg_index == REG_IMAGE_WIDTH ||
                             cfg_index == REG_IMAGE_HEIGHT ||
                             cfg_index == REG_COLOR_MODE);
    kernel.top    = ktop_r;
    kernel.middle = kmid_r;
    kernel.bottom = kbot_r;
  end

  c3zpc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .geom     (geom),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  c3zpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  c3zpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .kernel    (kernel),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Input is held back only by a full queue
  a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_full)
    else $error("input stalled while queue has room");

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue push while full");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  // Reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire

[rtl/c3zpc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3zpc_front - input side: frame position, line stores and 3x3 window
// Accepts items, classifies them as pixel or padding, keeps the two line
// stores and the window, and pushes every item that emits a result.
// ----------------------------------------------------------------------------
module c3zpc_front
  import c3zpc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire geom_t    geom,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output q_entry_t      q_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = $clog2(MAX_WIDTH + 2);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int OW = $clog2(MAX_HEIGHT);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  // Input position, warm-up count and output position
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [XW-1:0] warm_r, warm_nxt;
  logic [CW-1:0] ocol_r, ocol_nxt;
  logic [OW-1:0] orow_r, orow_nxt;

  logic          acc;
  logic          b_move;
  pix_t          pix_a;
  logic          col_wrap, ocol_wrap, orow_final;
  logic          emit_a, last_a;
  logic [TAPS-1:0] tap_a;
  logic [2:0]    row_en, col_en;

  // Line stores
  pix_t store_upper_r [MAX_WIDTH];
  pix_t store_lower_r [MAX_WIDTH];
  pix_t rd_upper_r, rd_lower_r;
  logic fwd_r;
  pix_t fwd_data_r;
  pix_t above1, above2;

  // Second stage
  logic            b_valid_r;
  logic [CW-1:0]   b_col_r;
  pix_t            b_pix_r;
  logic            b_emit_r;
  logic            b_last_r;
  logic [TAPS-1:0] b_tap_r;
  logic            b_color_r;

  win_t win_r, win_nxt;

  // Clamp the frame size to 1..maximum
  always_comb begin
    if (geom.width == '0) begin
      w_eff = WW'(1);
    end else if (32'(geom.width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(geom.width);
    end
    if (geom.height == '0) begin
      h_eff = HW'(1);
    end else if (32'(geom.height) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(geom.height);
    end
  end

  // Handshake: hold the input only while an emitting item waits on a full queue
  assign in_stall = b_valid_r && b_emit_r && q_full;
  assign acc      = in_valid && !in_stall;
  assign b_move   = b_valid_r && (!b_emit_r || !q_full);
  assign q_push   = b_valid_r && b_emit_r && !q_full;

  // Classify the item: pixel inside the frame, otherwise zero
  always_comb begin
    pix_a = '0;
    if ((row_r < RW'(h_eff)) && !in_data.operation) begin
      pix_a[SAMPLE_W-1:0] = in_data.sample0;
      if (geom.color) begin
        pix_a[2*SAMPLE_W-1:SAMPLE_W]       = in_data.sample1;
        pix_a[3*SAMPLE_W-1:2*SAMPLE_W]     = in_data.sample2;
      end
    end
  end

  // Output position and border taps of the pixel this item completes
  assign col_wrap   = (WW'(col_r) + WW'(1)) == w_eff;
  assign ocol_wrap  = (WW'(ocol_r) + WW'(1)) == w_eff;
  assign orow_final = (HW'(orow_r) + HW'(1)) == h_eff;
  assign emit_a     = warm_r == (XW'(w_eff) + XW'(1));
  assign last_a     = emit_a && ocol_wrap && orow_final;
  assign row_en     = {!orow_final, 1'b1, orow_r != '0};
  assign col_en     = {!ocol_wrap, 1'b1, ocol_r != '0};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        tap_a[i*3+j] = row_en[i] && col_en[j];
      end
    end
  end

  // Advance the position counters; frame end and geometry writes clear them
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    warm_nxt = warm_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (acc) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
      if (emit_a) begin
        if (ocol_wrap) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + OW'(1);
        end else begin
          ocol_nxt = ocol_r + CW'(1);
        end
      end else begin
        warm_nxt = warm_r + XW'(1);
      end
      if (last_a) begin
        col_nxt  = '0;
        row_nxt  = '0;
        warm_nxt = '0;
        ocol_nxt = '0;
        orow_nxt = '0;
      end
    end
    if (geom.clear) begin
      col_nxt  = '0;
      row_nxt  = '0;
      warm_nxt = '0;
      ocol_nxt = '0;
      orow_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      warm_r <= '0;
      ocol_r <= '0;
      orow_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      warm_r <= warm_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
    end
  end

  // Lower store: write the new pixel, read the one from the row above
  always_ff @(posedge clk) begin
    if (acc) begin
      store_lower_r[col_r] <= pix_a;
      rd_lower_r           <= store_lower_r[col_r];
    end
  end

  // Upper store: take the lower row when the item leaves the second stage
  always_ff @(posedge clk) begin
    if (b_move) begin
      store_upper_r[b_col_r] <= above1;
    end
    if (acc) begin
      rd_upper_r <= store_upper_r[col_r];
    end
  end

  // Forward the upper write when the next item reads the same column
  assign above1 = rd_lower_r;
  assign above2 = fwd_r ? fwd_data_r : rd_upper_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (acc) begin
      b_valid_r <= 1'b1;
    end else if (b_move) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_col_r    <= col_r;
      b_pix_r    <= pix_a;
      b_emit_r   <= emit_a;
      b_last_r   <= last_a;
      b_tap_r    <= tap_a;
      b_color_r  <= geom.color;
      fwd_r      <= b_move && (b_col_r == col_r);
      fwd_data_r <= rd_lower_r;
    end
  end

  // Shift the window one column and load the new right-hand column
  always_comb begin
    win_nxt = win_r;
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = above2;
    win_nxt[1][2] = above1;
    win_nxt[2][2] = b_pix_r;
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      win_r <= win_nxt;
    end
  end

  always_comb begin
    q_data.win    = win_nxt;
    q_data.tap_en = b_tap_r;
    q_data.color  = b_color_r;
    q_data.last   = b_last_r;
  end

endmodule
`default_nettype wire

[rtl/c3zpc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3zpc_queue - short queue between the window front and the filter back
// Register-based queue of filled windows; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module c3zpc_queue
  import c3zpc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_data,
  output logic          full,
  input  wire logic     pop,
  output q_entry_t      pop_data,
  output logic          empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  q_entry_t        slot_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]   count_r;

  assign full     = count_r == NW'(DEPTH);
  assign empty    = count_r == '0;
  assign pop_data = slot_r[rd_ptr_r];

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/c3zpc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3zpc_back - filter side: tap products, sum, clamp and output register
// Stage one forms the 27 truncated Q4.4 tap products, stage two sums each
// channel, clamps to 0..255 and holds the result item for the consumer.
// ----------------------------------------------------------------------------
module c3zpc_back
  import c3zpc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire kernel_t  kernel,
  input  wire logic     q_empty,
  input  wire q_entry_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  logic [KROW_W-1:0] krow [3];

  logic o_load, p_load;
  logic p_valid_r, o_valid_r;

  logic signed [PROD_W-1:0] prod_c [3][TAPS];
  logic signed [PROD_W-1:0] p_prod_r [3][TAPS];
  logic                     p_last_r, p_color_r;

  logic [SAMPLE_W-1:0] clamp_c [3];
  out_item_t           out_data_r;

  assign krow[0] = kernel.top;
  assign krow[1] = kernel.middle;
  assign krow[2] = kernel.bottom;

  // Pipeline flow: each stage loads when the one after it has room
  assign o_load = !o_valid_r || !out_stall;
  assign p_load = !p_valid_r || o_load;
  assign q_pop  = p_load && !q_empty;

  // Tap products, truncated toward zero; border taps forced to zero
  always_comb begin
    logic        [SAMPLE_W-1:0] smp;
    logic signed [SAMPLE_W-1:0] cf;
    logic signed [16:0]         full_p;
    logic signed [16:0]         adj_p;
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          smp    = q_data.win[i][j][SAMPLE_W*ch +: SAMPLE_W];
          cf     = $signed(krow[i][SAMPLE_W*j +: SAMPLE_W]);
          full_p = $signed({1'b0, smp}) * cf;
          adj_p  = full_p + (full_p[16] ? 17'sd15 : 17'sd0);
          prod_c[ch][i*3+j] = q_data.tap_en[i*3+j] ? PROD_W'(adj_p >>> 4) : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (p_load) begin
      p_valid_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p_prod_r  <= prod_c;
      p_last_r  <= q_data.last;
      p_color_r <= q_data.color;
    end
  end

  // Sum each channel and clamp to the sample range
  always_comb begin
    logic signed [SUM_W-1:0] s;
    for (int ch = 0; ch < 3; ch++) begin
      s = '0;
      for (int k = 0; k < TAPS; k++) begin
        s = s + SUM_W'(p_prod_r[ch][k]);
      end
      if (s[SUM_W-1]) begin
        clamp_c[ch] = '0;
      end else if (s[SUM_W-2:SAMPLE_W] != '0) begin
        clamp_c[ch] = SAMPLE_MAX;
      end else begin
        clamp_c[ch] = s[SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (o_load) begin
      o_valid_r <= p_valid_r;
    end
  end

  // Hold the result item; green and blue read zero in grayscale
  always_ff @(posedge clk) begin
    if (o_load && p_valid_r) begin
      out_data_r.out0       <= clamp_c[0];
      out_data_r.out1       <= p_color_r ? clamp_c[1] : '0;
      out_data_r.out2       <= p_color_r ? clamp_c[2] : '0;
      out_data_r.last_pixel <= p_last_r;
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
